@@ hdl/cdq_pkg.sv @@
// Package for the circular deque: widths, opcodes, cell commands and the result record.
// Used by cdq_cell and circular_deque_ring_buffer. It depends on nothing else.
package cdq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 72;

  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
  localparam logic [DATA_W-1:0] EMPTY_VAL = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_QUERY     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SHR,
    CELL_SHL,
    CELL_LOAD_BACK,
    CELL_DROP_BACK
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] back;
    logic [DATA_W-1:0] front;
    logic              accepted;
  } result_t;

endpackage

@@ hdl/cdq_cell.sv @@
// One slot of the deque chain: a data word and an occupied bit, taken from a neighbor on a shift.
// Depends on cdq_pkg for the cell command and data width.
module cdq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cdq_pkg::cell_ctrl_t        ctrl_i,
  input  logic [cdq_pkg::DATA_W-1:0] left_data_i,
  input  logic                       left_valid_i,
  input  logic [cdq_pkg::DATA_W-1:0] right_data_i,
  input  logic                       right_valid_i,
  output logic [cdq_pkg::DATA_W-1:0] data_o,
  output logic                       valid_o,
  output logic [cdq_pkg::DATA_W-1:0] back_o
);

  logic [cdq_pkg::DATA_W-1:0] data_q, data_d;
  logic                       valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      cdq_pkg::CELL_HOLD: begin
      end
      cdq_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      cdq_pkg::CELL_SHR: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      cdq_pkg::CELL_SHL: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      cdq_pkg::CELL_LOAD_BACK: begin
        valid_d = left_valid_i;
        if (!valid_q && left_valid_i) begin
          data_d = ctrl_i.value;
        end
      end
      cdq_pkg::CELL_DROP_BACK: begin
        valid_d = right_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign back_o  = (valid_q && !right_valid_i) ? data_q : '0;

endmodule

@@ hdl/circular_deque_ring_buffer.sv @@
// Top level of the deque: a chain of cdq_cell slots with the front at cell 0, plus control.
// A result beat shows the cells after its operation and is registered before it is offered.
// Throughput: one beat per cycle unless output or cfg stalls; one chain shift per op.
// Reset clears all occupied bits, the element count and the pending result; capacity is 64.
// Writing capacity empties the deque in the same cycle.
module circular_deque_ring_buffer #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: opcode[2:0], item_value[34:3], zero fill.
  input  logic [cdq_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: accepted[0], front_value[32:1], back_value[64:33],
  // empty_flag[65], full_flag[66], zero fill.
  output logic [cdq_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cdq_pkg::CAP_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned KW = ((CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W) + 1;
  localparam int unsigned DW = cdq_pkg::DATA_W;

  logic [cdq_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]             count_q, count_d;
  logic                      pend_q, pend_d;
  logic                      acc_q, acc_d;
  logic                      m_valid_q, m_valid_d;
  cdq_pkg::result_t          out_q;
  cdq_pkg::result_t          res;

  cdq_pkg::cell_ctrl_t ctrl;
  cdq_pkg::op_e        op;
  logic [DW-1:0]       item_value;
  logic                in_fire, cfg_fire, out_free, load_out;
  logic [KW-1:0]       cap_ext, k_ext;
  logic [CW-1:0]       k;
  logic                full_now, empty_now;

  logic [DW-1:0]        cell_data [MAX_DEPTH];
  logic [DW-1:0]        cell_back [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] cell_valid;
  logic [MAX_DEPTH-1:0] back_col [DW];
  logic [DW-1:0]        back_val;

  assign op         = cdq_pkg::op_e'(s_axis_tdata[cdq_pkg::OP_W-1:0]);
  assign item_value = s_axis_tdata[cdq_pkg::OP_W +: DW];

  assign cfg_ready_o   = !pend_q;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign load_out      = pend_q && out_free;
  assign s_axis_tready = (!pend_q || out_free) && !cfg_valid_i;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cap_ext = KW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      k_ext = KW'(1);
    end else if (cap_ext > KW'(MAX_DEPTH)) begin
      k_ext = KW'(MAX_DEPTH);
    end else begin
      k_ext = cap_ext;
    end
  end
  assign k = k_ext[CW-1:0];

  assign full_now  = (count_q == k);
  assign empty_now = (count_q == '0);

  always_comb begin
    ctrl.op    = cdq_pkg::CELL_HOLD;
    ctrl.value = item_value;
    count_d    = count_q;
    acc_d      = acc_q;
    if (cfg_fire) begin
      ctrl.op = cdq_pkg::CELL_CLEAR;
      count_d = '0;
    end else if (in_fire) begin
      acc_d = 1'b0;
      case (op)
        cdq_pkg::OP_INS_FRONT: begin
          if (!full_now) begin
            ctrl.op = cdq_pkg::CELL_SHR;
            count_d = count_q + CW'(1);
            acc_d   = 1'b1;
          end
        end
        cdq_pkg::OP_INS_BACK: begin
          if (!full_now) begin
            ctrl.op = cdq_pkg::CELL_LOAD_BACK;
            count_d = count_q + CW'(1);
            acc_d   = 1'b1;
          end
        end
        cdq_pkg::OP_DEL_FRONT: begin
          if (!empty_now) begin
            ctrl.op = cdq_pkg::CELL_SHL;
            count_d = count_q - CW'(1);
            acc_d   = 1'b1;
          end
        end
        cdq_pkg::OP_DEL_BACK: begin
          if (!empty_now) begin
            ctrl.op = cdq_pkg::CELL_DROP_BACK;
            count_d = count_q - CW'(1);
            acc_d   = 1'b1;
          end
        end
        cdq_pkg::OP_QUERY: begin
          acc_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic [DW-1:0] left_data, right_data;
    logic          left_valid, right_valid;
    if (i == 0) begin : g_first
      assign left_data  = item_value;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end
    if (i == MAX_DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end
    cdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[i]),
      .valid_o       (cell_valid[i]),
      .back_o        (cell_back[i])
    );
  end

  for (genvar b = 0; b < DW; b++) begin : g_bit
    for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_col
      assign back_col[b][i] = cell_back[i][b];
    end
    assign back_val[b] = |back_col[b];
  end

  always_comb begin
    res.accepted = acc_q;
    res.empty    = !cell_valid[0];
    res.full     = full_now;
    res.front    = cell_valid[0] ? cell_data[0] : cdq_pkg::EMPTY_VAL;
    res.back     = cell_valid[0] ? back_val : cdq_pkg::EMPTY_VAL;
  end

  always_comb begin
    pend_d = pend_q;
    if (in_fire) begin
      pend_d = 1'b1;
    end else if (load_out) begin
      pend_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= cdq_pkg::CAP_RESET;
      count_q   <= '0;
      pend_q    <= 1'b0;
      acc_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_fire) begin
        cap_q <= cfg_data_i;
      end
      count_q   <= count_d;
      pend_q    <= pend_d;
      acc_q     <= acc_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(cdq_pkg::M_TDATA_W - $bits(cdq_pkg::result_t))'(0), out_q};

  a_count_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("occupied cells disagree with element count");

  a_full_insert_refused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_fire && full_now &&
     (op == cdq_pkg::OP_INS_FRONT || op == cdq_pkg::OP_INS_BACK))
    |=> $stable(count_q) && !acc_q)
    else $error("insert into a full deque was not refused");

  a_empty_reports_minus_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q.empty) |->
    (out_q.front == cdq_pkg::EMPTY_VAL && out_q.back == cdq_pkg::EMPTY_VAL))
    else $error("empty result beat carries element values");

endmodule
